// ===== design/sliding_window_statistics_defines.svh =====
// sliding_window_statistics_defines.svh
// assertion macros for the sliding window statistics block
// the including module supplies aclk and aresetn
`ifndef SLIDING_WINDOW_STATISTICS_DEFINES_SVH
`define SLIDING_WINDOW_STATISTICS_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define SWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sliding window statistics check failed");

// next-cycle implication, sampled on aclk, off during reset
`define SWS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sliding window statistics check failed");

`endif

// ===== design/swstat_pkg.sv =====
// swstat_pkg.sv
// shared constants and types for the sliding window statistics block
// no dependencies
`timescale 1ns / 1ps

package swstat_pkg;

    // window geometry
    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int AGE_W   = 4;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = DATA_W + $clog2(DEPTH) + 1;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    // packed request widths
    localparam int IN_BITS  = MODE_W + DATA_W + AGE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = CNT_W + 1 + 5 * DATA_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;

    // commands to the window store
    typedef struct packed {
        logic drop;
        logic ins;
        logic clr;
    } st_cmd_t;

endpackage

// ===== design/swstat_store.sv =====
// swstat_store.sv
// sample window shift line, sorted copy with insert/drop cells, running sum
// depends on swstat_pkg
`timescale 1ns / 1ps

module swstat_store (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  swstat_pkg::st_cmd_t                   cmd,
    input  logic signed [swstat_pkg::DATA_W-1:0]  sample,
    input  logic [swstat_pkg::IDX_W-1:0]          win_idx,
    input  logic [swstat_pkg::IDX_W-1:0]          sort_idx,
    output logic [swstat_pkg::CNT_W-1:0]          cnt,
    output logic signed [swstat_pkg::SUM_W-1:0]   sum,
    output logic signed [swstat_pkg::DATA_W-1:0]  win_data,
    output logic signed [swstat_pkg::DATA_W-1:0]  sort_data
);

    logic signed [swstat_pkg::DATA_W-1:0] win_reg  [swstat_pkg::DEPTH];
    logic signed [swstat_pkg::DATA_W-1:0] sort_reg [swstat_pkg::DEPTH];
    logic signed [swstat_pkg::DATA_W-1:0] sort_next[swstat_pkg::DEPTH];
    logic signed [swstat_pkg::DATA_W-1:0] rem_val  [swstat_pkg::DEPTH];
    logic signed [swstat_pkg::DATA_W-1:0] ins_val  [swstat_pkg::DEPTH];
    logic [swstat_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [swstat_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic signed [swstat_pkg::DATA_W-1:0] oldest;
    logic [swstat_pkg::DEPTH-1:0]         gt;
    logic                                 hit;

    // drop cells: remove first copy of the oldest sample, close the gap
    always_comb begin
        oldest = win_reg[swstat_pkg::DEPTH-1];
        hit    = 1'b0;
        for (int k = 0; k < swstat_pkg::DEPTH; k++) begin
            hit = hit | ((swstat_pkg::CNT_W'(k) < cnt_reg) && (sort_reg[k] == oldest));
            if (hit && (k < swstat_pkg::DEPTH - 1)) begin
                rem_val[k] = sort_reg[(k + 1) % swstat_pkg::DEPTH];
            end else begin
                rem_val[k] = sort_reg[k];
            end
        end
    end

    // insert cells: entries above the new sample move up one place
    always_comb begin
        for (int k = 0; k < swstat_pkg::DEPTH; k++) begin
            gt[k] = (swstat_pkg::CNT_W'(k) < cnt_reg) && (sort_reg[k] > sample);
        end
        for (int k = 0; k < swstat_pkg::DEPTH; k++) begin
            if ((swstat_pkg::CNT_W'(k) < cnt_reg) && !gt[k]) begin
                ins_val[k] = sort_reg[k];
            end else if ((k > 0) && gt[(k + swstat_pkg::DEPTH - 1) % swstat_pkg::DEPTH]) begin
                ins_val[k] = sort_reg[(k + swstat_pkg::DEPTH - 1) % swstat_pkg::DEPTH];
            end else begin
                ins_val[k] = sample;
            end
        end
    end

    // next state of count, sum and sorted copy
    always_comb begin
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        sort_next = sort_reg;
        if (cmd.clr) begin
            cnt_next = '0;
            sum_next = '0;
        end else if (cmd.drop) begin
            cnt_next  = cnt_reg - 1'b1;
            sum_next  = sum_reg - {{(swstat_pkg::SUM_W - swstat_pkg::DATA_W){oldest[swstat_pkg::DATA_W-1]}}, oldest};
            sort_next = rem_val;
        end else if (cmd.ins) begin
            cnt_next  = cnt_reg + 1'b1;
            sum_next  = sum_reg + {{(swstat_pkg::SUM_W - swstat_pkg::DATA_W){sample[swstat_pkg::DATA_W-1]}}, sample};
            sort_next = ins_val;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end

    // window shift line and sorted copy, no reset
    always_ff @(posedge aclk) begin
        sort_reg <= sort_next;
        if (cmd.ins) begin
            win_reg[0] <= sample;
            for (int k = 1; k < swstat_pkg::DEPTH; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    assign cnt       = cnt_reg;
    assign sum       = sum_reg;
    assign win_data  = win_reg[win_idx];
    assign sort_data = sort_reg[sort_idx];

endmodule

// ===== design/swstat_div.sv =====
// swstat_div.sv
// serial restoring divider, one quotient bit a cycle, sum over count
// depends on swstat_pkg
`timescale 1ns / 1ps

module swstat_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [swstat_pkg::SUM_W-1:0]   dividend,
    input  logic [swstat_pkg::CNT_W-1:0]          divisor,
    output logic                                  busy,
    output logic signed [swstat_pkg::DATA_W-1:0]  quotient
);

    logic                          busy_reg;
    logic [swstat_pkg::STEP_W-1:0] step_reg;
    logic [swstat_pkg::SUM_W-1:0]  q_reg, q_next;
    logic [swstat_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [swstat_pkg::CNT_W-1:0]  dvs_reg;
    logic                          neg_reg;
    logic [swstat_pkg::CNT_W:0]    trial;
    logic [swstat_pkg::CNT_W:0]    diff;
    logic                          ge;

    // one restoring step
    always_comb begin
        trial    = {rem_reg, q_reg[swstat_pkg::SUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[swstat_pkg::CNT_W-1:0] : trial[swstat_pkg::CNT_W-1:0];
        q_next   = {q_reg[swstat_pkg::SUM_W-2:0], ge};
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= swstat_pkg::STEP_W'(swstat_pkg::SUM_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == swstat_pkg::STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath, magnitude divide with sign restored at the end
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend[swstat_pkg::SUM_W-1] ? -dividend : dividend;
            neg_reg <= dividend[swstat_pkg::SUM_W-1];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -q_reg[swstat_pkg::DATA_W-1:0] : q_reg[swstat_pkg::DATA_W-1:0];

endmodule

// ===== design/sliding_window_statistics.sv =====
// sliding window statistics: an add request passes the drop, insert, gather
// and wait states before result valid, clear and report only gather and wait;
// one request at a time, waiting for a free output register and for the serial
// divider that turns the running sum into the mean, one bit a cycle
// synchronous active-low reset empties the window; sample storage is not cleared
// depends on swstat_pkg, swstat_store, swstat_div and the defines header
`timescale 1ns / 1ps
`include "sliding_window_statistics_defines.svh"

module sliding_window_statistics (
    input  logic                            aclk,
    input  logic                            aresetn,
    // mode[1:0], sample[33:2], read_index[37:34], zero pad
    input  logic [swstat_pkg::IN_W-1:0]     s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fill_level, window_empty, minimum, maximum, average, middle_value,
    // aged_sample, age_valid, zero pad
    output logic [swstat_pkg::OUT_W-1:0]    m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DROP   = 3'd1;
    localparam logic [2:0] ST_INS    = 3'd2;
    localparam logic [2:0] ST_GATHER = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;

    logic [2:0]                            state_reg, state_next;
    logic [1:0]                            ph_reg, ph_next;
    logic signed [swstat_pkg::DATA_W-1:0]  sample_reg;
    logic [swstat_pkg::AGE_W-1:0]          age_reg;
    logic signed [swstat_pkg::DATA_W-1:0]  min_reg, max_reg, hi_reg, lo_reg;
    swstat_pkg::st_cmd_t                   cmd;
    logic [swstat_pkg::CNT_W-1:0]          cnt;
    logic signed [swstat_pkg::SUM_W-1:0]   sum;
    logic signed [swstat_pkg::DATA_W-1:0]  win_data, sort_data, quotient;
    logic [swstat_pkg::IDX_W-1:0]          sort_idx;
    logic [swstat_pkg::CNT_W-1:0]          idx_full;
    logic                                  div_busy, div_start;
    logic                                  accept, out_free, load;
    logic [swstat_pkg::MODE_W-1:0]         in_mode;
    logic                                  empty, age_ok;
    logic signed [swstat_pkg::DATA_W:0]    mid_sum;
    logic signed [swstat_pkg::DATA_W-1:0]  med;

    // output register
    logic                                  m_tvalid_reg;
    logic [swstat_pkg::CNT_W-1:0]          out_fill;
    logic                                  out_empty, out_age_ok;
    logic signed [swstat_pkg::DATA_W-1:0]  out_min, out_max, out_avg, out_med, out_aged;

    assign in_mode  = s_tdata[swstat_pkg::MODE_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = (state_reg == ST_WAIT) && !div_busy && out_free;

    // sequencer
    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ph_next = '0;
                    if (in_mode == swstat_pkg::MODE_ADD) begin
                        state_next = ST_DROP;
                    end else begin
                        cmd.clr    = (in_mode == swstat_pkg::MODE_CLEAR);
                        state_next = ST_GATHER;
                    end
                end
            end
            ST_DROP: begin
                cmd.drop   = (cnt == swstat_pkg::CNT_W'(swstat_pkg::DEPTH));
                state_next = ST_INS;
            end
            ST_INS: begin
                cmd.ins    = 1'b1;
                state_next = ST_GATHER;
            end
            ST_GATHER: begin
                div_start = (ph_reg == 2'd0);
                ph_next   = ph_reg + 1'b1;
                if (ph_reg == 2'd3) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ph_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    // capture the request fields
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_tdata[swstat_pkg::MODE_W +: swstat_pkg::DATA_W];
            age_reg    <= s_tdata[swstat_pkg::MODE_W + swstat_pkg::DATA_W +: swstat_pkg::AGE_W];
        end
    end

    // one sorted read a cycle: min, max, upper and lower middle
    always_comb begin
        case (ph_reg)
            2'd0:    idx_full = '0;
            2'd1:    idx_full = cnt - 1'b1;
            2'd2:    idx_full = cnt >> 1;
            default: idx_full = (cnt - 1'b1) >> 1;
        endcase
        sort_idx = idx_full[swstat_pkg::IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_GATHER) begin
            case (ph_reg)
                2'd0:    min_reg <= sort_data;
                2'd1:    max_reg <= sort_data;
                2'd2:    hi_reg  <= sort_data;
                default: lo_reg  <= sort_data;
            endcase
        end
    end

    swstat_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sample    (sample_reg),
        .win_idx   (swstat_pkg::IDX_W'(age_reg)),
        .sort_idx  (sort_idx),
        .cnt       (cnt),
        .sum       (sum),
        .win_data  (win_data),
        .sort_data (sort_data)
    );

    swstat_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sum),
        .divisor   (cnt),
        .busy      (div_busy),
        .quotient  (quotient)
    );

    // median and report fields
    always_comb begin
        empty   = (cnt == '0);
        age_ok  = int'(age_reg) < int'(cnt);
        mid_sum = {hi_reg[swstat_pkg::DATA_W-1], hi_reg} + {lo_reg[swstat_pkg::DATA_W-1], lo_reg};
        med     = cnt[0] ? hi_reg : mid_sum[swstat_pkg::DATA_W:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_fill   <= cnt;
            out_empty  <= empty;
            out_min    <= empty ? '0 : min_reg;
            out_max    <= empty ? '0 : max_reg;
            out_avg    <= empty ? '0 : quotient;
            out_med    <= empty ? '0 : med;
            out_aged   <= age_ok ? win_data : '0;
            out_age_ok <= age_ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(swstat_pkg::OUT_W - swstat_pkg::OUT_BITS){1'b0}},
                       out_age_ok, out_aged, out_med, out_avg, out_max, out_min,
                       out_empty, out_fill};

    // checks
    `SWS_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= swstat_pkg::CNT_W'(swstat_pkg::DEPTH))
    `SWS_ASSERT_IMP(a_empty_flag, m_tvalid_reg, out_empty == (out_fill == '0))
    `SWS_ASSERT_IMP(a_empty_zero, m_tvalid_reg && out_empty, out_min == '0 && out_max == '0 && out_avg == '0)
    `SWS_ASSERT_NXT(a_result_after_div, state_reg == ST_WAIT && !div_busy && out_free, m_tvalid_reg)

endmodule
